@@ rtl/wss_pkg.sv @@
package wss_pkg;

    localparam int LAT_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [LAT_W-1:0]     RST_COOLDOWN  = 16'd0;
    localparam logic [TIME_W-1:0]    RST_MAX_AGE   = 32'd10000;
    localparam logic [CNT_OUT_W-1:0] RST_MAX_COUNT = 5'd15;
    localparam logic [LAT_W-1:0]     RST_DEFAULT   = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COOLDOWN  = 2'd0,
        REG_MAX_AGE   = 2'd1,
        REG_MAX_COUNT = 2'd2,
        REG_DEFAULT   = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_CLEAR  = 1'b1
    } req_t;

    typedef struct packed {
        logic              push;
        logic              age_chk;
        logic              clr;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] max_age;
    } cell_ctrl_t;

endpackage

@@ rtl/wss_ifs.sv @@
interface wss_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] time_now_ms;
    logic [15:0] latency_sample;

    modport source (output valid, req_type, time_now_ms, latency_sample, input ready);
    modport sink (input valid, req_type, time_now_ms, latency_sample, output ready);
endinterface

interface wss_out_if;
    logic        valid;
    logic        ready;
    logic        stored;
    logic [15:0] current_latency;
    logic [4:0]  entry_count;
    logic [15:0] average_latency;
    logic [15:0] min_latency;
    logic [15:0] max_latency;

    modport source (output valid, stored, current_latency, entry_count, average_latency,
                    min_latency, max_latency, input ready);
    modport sink (input valid, stored, current_latency, entry_count, average_latency,
                  min_latency, max_latency, output ready);
endinterface

@@ rtl/wss_cell.sv @@
module wss_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5,
    parameter int SUM_W = 21
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wss_pkg::cell_ctrl_t         ctrl,
    input  logic [CNT_W-1:0]            lim,
    input  logic                        prev_valid,
    input  logic [wss_pkg::TIME_W-1:0]  prev_time,
    input  logic [wss_pkg::LAT_W-1:0]   prev_lat,
    output logic                        valid,
    output logic [wss_pkg::TIME_W-1:0]  time_q,
    output logic [wss_pkg::LAT_W-1:0]   lat_q,
    input  logic [SUM_W-1:0]            prev_sum,
    input  logic [CNT_W-1:0]            prev_cnt,
    input  logic [wss_pkg::LAT_W-1:0]   prev_min,
    input  logic [wss_pkg::LAT_W-1:0]   prev_max,
    output logic [SUM_W-1:0]            acc_sum,
    output logic [CNT_W-1:0]            acc_cnt,
    output logic [wss_pkg::LAT_W-1:0]   acc_min,
    output logic [wss_pkg::LAT_W-1:0]   acc_max
);

    logic                       valid_reg, valid_next;
    logic [wss_pkg::TIME_W-1:0] time_reg, time_next;
    logic [wss_pkg::LAT_W-1:0]  lat_reg, lat_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [wss_pkg::LAT_W-1:0]  min_reg, min_next;
    logic [wss_pkg::LAT_W-1:0]  max_reg, max_next;
    logic [wss_pkg::TIME_W-1:0] age;
    logic                       too_old;

    // age is clamped at zero for entries stamped later than now
    always_comb
    begin
        age     = (time_reg > ctrl.now) ? '0 : ctrl.now - time_reg;
        too_old = age > ctrl.max_age;
    end

    always_comb
    begin
        valid_next = valid_reg;
        time_next  = time_reg;
        lat_next   = lat_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.push)
        begin
            // entries beyond the count limit fall off the end of the chain
            valid_next = prev_valid && (CNT_W'(IDX) < lim);
            time_next  = prev_time;
            lat_next   = prev_lat;
        end
        else if (ctrl.age_chk)
        begin
            valid_next = valid_reg && !too_old;
        end
    end

    // running statistics travel one cell per cycle
    always_comb
    begin
        sum_next = prev_sum + (valid_reg ? SUM_W'(lat_reg) : '0);
        cnt_next = prev_cnt + CNT_W'(valid_reg);
        min_next = (valid_reg && lat_reg < prev_min) ? lat_reg : prev_min;
        max_next = (valid_reg && lat_reg > prev_max) ? lat_reg : prev_max;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        lat_reg  <= lat_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        min_reg  <= min_next;
        max_reg  <= max_next;
    end

    assign valid   = valid_reg;
    assign time_q  = time_reg;
    assign lat_q   = lat_reg;
    assign acc_sum = sum_reg;
    assign acc_cnt = cnt_reg;
    assign acc_min = min_reg;
    assign acc_max = max_reg;

endmodule

@@ rtl/wss_div.sv @@
module wss_div #(
    parameter int SUM_W = 21,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        fits    = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_reg  <= {quo_reg[SUM_W-2:0], fits};
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/windowed_sample_statistics.sv @@
// Windowed latency statistics over the last WINDOW_DEPTH stored samples. Each item is a
// timed sample or a clear request and gives one result: whether the sample was stored,
// the current value, the entry count, the floor average and the window minimum and
// maximum. Entries sit in a chain of cells, newest first; a store shifts the chain by
// one, trims it to the count limit and then drops entries older than max_age_ms. One
// item is handled at a time; a new one is taken once the result is registered. The
// running sum, count, minimum and maximum ripple down the cell chain one cell a cycle,
// then a bit-serial SUM_W-bit divider (SUM_W = 16 + clog2(WINDOW_DEPTH + 1)) forms
// the average; an empty window skips the divider. Configuration is written via cfg_we /
// cfg_index / cfg_wdata, by the user only while idle; the block does not enforce it.
module windowed_sample_statistics #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wss_pkg::CFG_W-1:0]     cfg_wdata,
    wss_in_if.sink                        sample,
    wss_out_if.source                     result
);

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = wss_pkg::LAT_W + CNT_W;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_AGE,
        ST_FILL,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [wss_pkg::LAT_W-1:0]     cooldown_reg;
    logic [wss_pkg::TIME_W-1:0]    max_age_reg;
    logic [wss_pkg::CNT_OUT_W-1:0] max_count_reg;
    logic [wss_pkg::LAT_W-1:0]     default_reg;

    // item context
    wss_pkg::req_t              req_reg, req_next;
    logic [wss_pkg::TIME_W-1:0] now_reg, now_next;
    logic [wss_pkg::LAT_W-1:0]  lat_reg, lat_next;
    logic                       do_store_reg, do_store_next;
    logic [wss_pkg::LAT_W-1:0]  cur_reg, cur_next;
    logic [wss_pkg::TIME_W-1:0] last_store_reg, last_store_next;
    logic [wss_pkg::LAT_W-1:0]  last_avg_reg, last_avg_next;
    logic [FILL_W-1:0]          fill_cnt_reg, fill_cnt_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          out_stored_reg, out_stored_next;
    logic [wss_pkg::LAT_W-1:0]     out_cur_reg, out_cur_next;
    logic [wss_pkg::CNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [wss_pkg::LAT_W-1:0]     out_avg_reg, out_avg_next;
    logic [wss_pkg::LAT_W-1:0]     out_min_reg, out_min_next;
    logic [wss_pkg::LAT_W-1:0]     out_max_reg, out_max_next;

    logic                accept;
    logic                store_ok;
    logic [CNT_W-1:0]    lim;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_q;
    wss_pkg::cell_ctrl_t ctrl;

    logic                       ch_valid [0:WINDOW_DEPTH];
    logic [wss_pkg::TIME_W-1:0] ch_time  [0:WINDOW_DEPTH];
    logic [wss_pkg::LAT_W-1:0]  ch_lat   [0:WINDOW_DEPTH];
    logic [SUM_W-1:0]           p_sum    [0:WINDOW_DEPTH];
    logic [CNT_W-1:0]           p_cnt    [0:WINDOW_DEPTH];
    logic [wss_pkg::LAT_W-1:0]  p_min    [0:WINDOW_DEPTH];
    logic [wss_pkg::LAT_W-1:0]  p_max    [0:WINDOW_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg  <= wss_pkg::RST_COOLDOWN;
            max_age_reg   <= wss_pkg::RST_MAX_AGE;
            max_count_reg <= wss_pkg::RST_MAX_COUNT;
            default_reg   <= wss_pkg::RST_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (wss_pkg::cfg_reg_t'(cfg_index))
                wss_pkg::REG_COOLDOWN:  cooldown_reg  <= cfg_wdata[wss_pkg::LAT_W-1:0];
                wss_pkg::REG_MAX_AGE:   max_age_reg   <= cfg_wdata[wss_pkg::TIME_W-1:0];
                wss_pkg::REG_MAX_COUNT: max_count_reg <= cfg_wdata[wss_pkg::CNT_OUT_W-1:0];
                wss_pkg::REG_DEFAULT:   default_reg   <= cfg_wdata[wss_pkg::LAT_W-1:0];
                default: ;
            endcase
        end
    end

    // count limit: zero acts as one, anything above the depth as the depth
    always_comb
    begin
        if (32'(max_count_reg) > 32'(WINDOW_DEPTH))
        begin
            lim = CNT_W'(WINDOW_DEPTH);
        end
        else if (max_count_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else
        begin
            lim = CNT_W'(max_count_reg);
        end
    end

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign store_ok     = (sample.time_now_ms > last_store_reg)
                       && ((sample.time_now_ms - last_store_reg)
                           > wss_pkg::TIME_W'(cooldown_reg));

    always_comb
    begin
        ctrl.push    = (state_reg == ST_PUSH) && do_store_reg;
        ctrl.clr     = (state_reg == ST_PUSH) && (req_reg == wss_pkg::REQ_CLEAR);
        ctrl.age_chk = (state_reg == ST_AGE) && do_store_reg;
        ctrl.now     = now_reg;
        ctrl.max_age = max_age_reg;
    end

    assign ch_valid[0] = 1'b1;
    assign ch_time[0]  = now_reg;
    assign ch_lat[0]   = lat_reg;
    assign p_sum[0]    = '0;
    assign p_cnt[0]    = '0;
    assign p_min[0]    = '1;
    assign p_max[0]    = '0;

    for (genvar g = 0; g < WINDOW_DEPTH; g++)
    begin : g_cell
        wss_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .SUM_W (SUM_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .lim        (lim),
            .prev_valid (ch_valid[g]),
            .prev_time  (ch_time[g]),
            .prev_lat   (ch_lat[g]),
            .valid      (ch_valid[g+1]),
            .time_q     (ch_time[g+1]),
            .lat_q      (ch_lat[g+1]),
            .prev_sum   (p_sum[g]),
            .prev_cnt   (p_cnt[g]),
            .prev_min   (p_min[g]),
            .prev_max   (p_max[g]),
            .acc_sum    (p_sum[g+1]),
            .acc_cnt    (p_cnt[g+1]),
            .acc_min    (p_min[g+1]),
            .acc_max    (p_max[g+1])
        );
    end

    wss_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (p_sum[WINDOW_DEPTH]),
        .divisor  (p_cnt[WINDOW_DEPTH]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        now_next        = now_reg;
        lat_next        = lat_reg;
        do_store_next   = do_store_reg;
        cur_next        = cur_reg;
        last_store_next = last_store_reg;
        last_avg_next   = last_avg_reg;
        fill_cnt_next   = fill_cnt_reg;
        div_start       = 1'b0;
        out_valid_next  = out_valid_reg && !result.ready;
        out_stored_next = out_stored_reg;
        out_cur_next    = out_cur_reg;
        out_cnt_next    = out_cnt_reg;
        out_avg_next    = out_avg_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next      = wss_pkg::req_t'(sample.req_type);
                    now_next      = sample.time_now_ms;
                    lat_next      = sample.latency_sample;
                    do_store_next = 1'b0;
                    if (sample.req_type == wss_pkg::REQ_CLEAR)
                    begin
                        cur_next = '0;
                    end
                    else
                    begin
                        cur_next = sample.latency_sample;
                        if (store_ok)
                        begin
                            do_store_next   = 1'b1;
                            last_store_next = sample.time_now_ms;
                        end
                    end
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                state_next = ST_AGE;
            end
            ST_AGE:
            begin
                fill_cnt_next = '0;
                state_next    = ST_FILL;
            end
            ST_FILL:
            begin
                // the last cell's totals are complete once they have crossed the chain
                if (fill_cnt_reg == FILL_W'(WINDOW_DEPTH))
                begin
                    if (p_cnt[WINDOW_DEPTH] != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    last_avg_next = div_q[wss_pkg::LAT_W-1:0];
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_stored_next = do_store_reg;
                    out_cur_next    = cur_reg;
                    out_cnt_next    = wss_pkg::CNT_OUT_W'(p_cnt[WINDOW_DEPTH]);
                    out_avg_next    = last_avg_reg;
                    if (p_cnt[WINDOW_DEPTH] == '0)
                    begin
                        out_min_next = default_reg;
                        out_max_next = default_reg;
                    end
                    else
                    begin
                        out_min_next = p_min[WINDOW_DEPTH];
                        out_max_next = p_max[WINDOW_DEPTH];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= wss_pkg::REQ_SAMPLE;
            now_reg        <= '0;
            lat_reg        <= '0;
            do_store_reg   <= 1'b0;
            cur_reg        <= '0;
            last_store_reg <= '0;
            last_avg_reg   <= wss_pkg::RST_DEFAULT;
            fill_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_stored_reg <= 1'b0;
            out_cur_reg    <= '0;
            out_cnt_reg    <= '0;
            out_avg_reg    <= '0;
            out_min_reg    <= '0;
            out_max_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            now_reg        <= now_next;
            lat_reg        <= lat_next;
            do_store_reg   <= do_store_next;
            cur_reg        <= cur_next;
            last_store_reg <= last_store_next;
            last_avg_reg   <= last_avg_next;
            fill_cnt_reg   <= fill_cnt_next;
            out_valid_reg  <= out_valid_next;
            out_stored_reg <= out_stored_next;
            out_cur_reg    <= out_cur_next;
            out_cnt_reg    <= out_cnt_next;
            out_avg_reg    <= out_avg_next;
            out_min_reg    <= out_min_next;
            out_max_reg    <= out_max_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.stored          = out_stored_reg;
    assign result.current_latency = out_cur_reg;
    assign result.entry_count     = out_cnt_reg;
    assign result.average_latency = out_avg_reg;
    assign result.min_latency     = out_min_reg;
    assign result.max_latency     = out_max_reg;

endmodule

@@ rtl/wss_checker.sv @@
module wss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sample_valid,
    input logic        sample_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic        stored,
    input logic [15:0] current_latency,
    input logic [15:0] min_latency,
    input logic [15:0] max_latency
);

    // one item at a time: no new item right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("input taken again straight after an item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
        else $error("result dropped before it was taken");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (min_latency <= max_latency))
        else $error("window minimum above maximum");

    // a stored sample is the newest entry, so it lies within the window's range
    a_stored_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && stored) |->
            ((min_latency <= current_latency) && (current_latency <= max_latency)))
        else $error("stored sample outside window range");

endmodule

bind windowed_sample_statistics wss_checker u_wss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample_valid    (sample.valid),
    .sample_ready    (sample.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .stored          (result.stored),
    .current_latency (result.current_latency),
    .min_latency     (result.min_latency),
    .max_latency     (result.max_latency)
);
